// ===== rtl/ctd_pkg.sv =====
`default_nettype none
package ctd_pkg;

   localparam int SIZE_BITS_DEF = 32;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CASE_BIT = 8'h20;

   typedef enum logic [2:0] {
      KIND_FRAME   = 3'd0,
      KIND_HEADER  = 3'd1,
      KIND_PAYLOAD = 3'd2,
      KIND_DONE    = 3'd3,
      KIND_ERROR   = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ST_START,
      ST_SIZE,
      ST_EXT,
      ST_EXT_CR,
      ST_DATA,
      ST_AFTER,
      ST_AFTER_CR,
      ST_LAST_EXT,
      ST_LAST_EXT_CR,
      ST_TRAILER,
      ST_TRAILER_CR,
      ST_THDR,
      ST_THDR_CR
   } state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
      logic       restart;
   } req_data_type;

   typedef struct packed {
      logic [2:0]  byte_kind;
      logic [7:0]  payload_byte;
      logic [31:0] chunk_size;
      logic [31:0] bytes_still_needed;
   } rsp_data_type;

endpackage
`default_nettype wire

// ===== rtl/ctd_if.sv =====
`default_nettype none
interface ctd_req_if;
   logic                  valid;
   logic                  ready;
   ctd_pkg::req_data_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ctd_rsp_if;
   logic                  valid;
   logic                  ready;
   ctd_pkg::rsp_data_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/ctd_step.sv =====
`default_nettype none
module ctd_step #(
   parameter int SIZE_BITS = ctd_pkg::SIZE_BITS_DEF
) (
   input  ctd_pkg::req_data_type req,
   input  ctd_pkg::state_type    state_cur,
   input  logic [SIZE_BITS-1:0]  rem_cur,
   input  logic                  err_cur,
   output ctd_pkg::state_type    state_nx,
   output logic [SIZE_BITS-1:0]  rem_nx,
   output logic                  err_nx,
   output ctd_pkg::rsp_data_type rsp
);

   ctd_pkg::state_type   st;
   logic [SIZE_BITS-1:0] rem;
   logic                 err;
   logic [7:0]           ch;
   logic [7:0]           lower;
   logic                 is_dig;
   logic                 is_alpha;
   logic                 is_hex;
   logic [3:0]           hv;
   logic                 size_full;

   ctd_pkg::state_type   st_dec;
   logic [SIZE_BITS-1:0] rem_dec;
   logic [SIZE_BITS-1:0] rem_less;
   ctd_pkg::kind_type    kind_dec;
   logic                 bad_dec;

   logic                 huge;
   logic [SIZE_BITS-1:0] sum5;
   logic [SIZE_BITS-1:0] sum4;
   logic [SIZE_BITS-1:0] need_val;
   logic [SIZE_BITS-1:0] size_val;
   logic                 bad;
   ctd_pkg::kind_type    kind;
   logic [SIZE_BITS+31:0] need_ext;
   logic [SIZE_BITS+31:0] size_ext;

   // restart acts before the byte is taken
   assign st  = req.restart ? ctd_pkg::ST_START : state_cur;
   assign rem = req.restart ? '0 : rem_cur;
   assign err = req.restart ? 1'b0 : err_cur;

   assign ch       = req.data_byte;
   assign lower    = ch | ctd_pkg::CASE_BIT;
   assign is_dig   = (ch >= 8'h30) && (ch <= 8'h39);
   assign is_alpha = (lower >= 8'h61) && (lower <= 8'h66);
   assign is_hex   = is_dig || is_alpha;
   assign hv       = is_dig ? ch[3:0] : 4'(lower - 8'h57);

   // another digit would overflow
   assign size_full = |rem[SIZE_BITS-1:SIZE_BITS-4];
   assign rem_less  = (rem != '0) ? rem - SIZE_BITS'(1) : '0;

   // next state
   always_comb begin
      st_dec   = st;
      rem_dec  = rem;
      kind_dec = ctd_pkg::KIND_FRAME;
      bad_dec  = 1'b0;
      if (!err) begin
         unique case (st)
            ctd_pkg::ST_START: begin
               if (!is_hex) begin
                  bad_dec = 1'b1;
               end else begin
                  rem_dec = SIZE_BITS'(hv);
                  st_dec  = ctd_pkg::ST_SIZE;
               end
            end
            ctd_pkg::ST_SIZE: begin
               if (size_full) begin
                  bad_dec = 1'b1;
               end else if (is_hex) begin
                  rem_dec = {rem[SIZE_BITS-5:0], hv};
               end else if (ch == ctd_pkg::CH_CR) begin
                  st_dec = (rem != '0) ? ctd_pkg::ST_EXT_CR : ctd_pkg::ST_LAST_EXT_CR;
               end else if (ch == ctd_pkg::CH_LF) begin
                  st_dec   = (rem != '0) ? ctd_pkg::ST_DATA : ctd_pkg::ST_TRAILER;
                  kind_dec = ctd_pkg::KIND_HEADER;
               end else if (ch == ctd_pkg::CH_SEMI || ch == ctd_pkg::CH_SPACE ||
                            ch == ctd_pkg::CH_TAB) begin
                  st_dec = (rem != '0) ? ctd_pkg::ST_EXT : ctd_pkg::ST_LAST_EXT;
               end else begin
                  bad_dec = 1'b1;
               end
            end
            ctd_pkg::ST_EXT: begin
               if (ch == ctd_pkg::CH_CR) begin
                  st_dec = ctd_pkg::ST_EXT_CR;
               end else if (ch == ctd_pkg::CH_LF) begin
                  st_dec   = ctd_pkg::ST_DATA;
                  kind_dec = ctd_pkg::KIND_HEADER;
               end
            end
            ctd_pkg::ST_EXT_CR: begin
               if (ch != ctd_pkg::CH_LF) begin
                  bad_dec = 1'b1;
               end else begin
                  st_dec   = ctd_pkg::ST_DATA;
                  kind_dec = ctd_pkg::KIND_HEADER;
               end
            end
            ctd_pkg::ST_DATA: begin
               kind_dec = ctd_pkg::KIND_PAYLOAD;
               rem_dec  = rem_less;
               if (rem_less == '0) begin
                  st_dec = ctd_pkg::ST_AFTER;
               end
            end
            ctd_pkg::ST_AFTER: begin
               if (ch == ctd_pkg::CH_CR) begin
                  st_dec = ctd_pkg::ST_AFTER_CR;
               end else if (ch == ctd_pkg::CH_LF) begin
                  st_dec = ctd_pkg::ST_START;
               end
            end
            ctd_pkg::ST_AFTER_CR: begin
               if (ch != ctd_pkg::CH_LF) begin
                  bad_dec = 1'b1;
               end else begin
                  st_dec = ctd_pkg::ST_START;
               end
            end
            ctd_pkg::ST_LAST_EXT: begin
               if (ch == ctd_pkg::CH_CR) begin
                  st_dec = ctd_pkg::ST_LAST_EXT_CR;
               end else if (ch == ctd_pkg::CH_LF) begin
                  st_dec   = ctd_pkg::ST_TRAILER;
                  kind_dec = ctd_pkg::KIND_HEADER;
               end
            end
            ctd_pkg::ST_LAST_EXT_CR: begin
               if (ch != ctd_pkg::CH_LF) begin
                  bad_dec = 1'b1;
               end else begin
                  st_dec   = ctd_pkg::ST_TRAILER;
                  kind_dec = ctd_pkg::KIND_HEADER;
               end
            end
            ctd_pkg::ST_TRAILER: begin
               if (ch == ctd_pkg::CH_CR) begin
                  st_dec = ctd_pkg::ST_TRAILER_CR;
               end else if (ch == ctd_pkg::CH_LF) begin
                  kind_dec = ctd_pkg::KIND_DONE;
               end else begin
                  st_dec = ctd_pkg::ST_THDR;
               end
            end
            ctd_pkg::ST_TRAILER_CR: begin
               if (ch != ctd_pkg::CH_LF) begin
                  bad_dec = 1'b1;
               end else begin
                  kind_dec = ctd_pkg::KIND_DONE;
               end
            end
            ctd_pkg::ST_THDR: begin
               if (ch == ctd_pkg::CH_CR) begin
                  st_dec = ctd_pkg::ST_THDR_CR;
               end else if (ch == ctd_pkg::CH_LF) begin
                  st_dec = ctd_pkg::ST_TRAILER;
               end
            end
            ctd_pkg::ST_THDR_CR: begin
               if (ch != ctd_pkg::CH_LF) begin
                  bad_dec = 1'b1;
               end else begin
                  st_dec = ctd_pkg::ST_TRAILER;
               end
            end
            default: begin
               bad_dec = 1'b1;
            end
         endcase
      end
   end

   // carry out of count + 5 means the count is within 5 of the top
   assign {huge, sum5} = {1'b0, rem_dec} + (SIZE_BITS+1)'(5);
   assign sum4         = rem_dec + SIZE_BITS'(4);

   always_comb begin
      unique case (st_dec)
         ctd_pkg::ST_START:       need_val = SIZE_BITS'(3);
         ctd_pkg::ST_SIZE:        need_val = (rem_dec != '0) ? sum5 : SIZE_BITS'(2);
         ctd_pkg::ST_EXT,
         ctd_pkg::ST_EXT_CR:      need_val = sum5;
         ctd_pkg::ST_DATA:        need_val = sum4;
         ctd_pkg::ST_AFTER,
         ctd_pkg::ST_AFTER_CR:    need_val = SIZE_BITS'(4);
         ctd_pkg::ST_LAST_EXT,
         ctd_pkg::ST_LAST_EXT_CR: need_val = SIZE_BITS'(2);
         ctd_pkg::ST_TRAILER,
         ctd_pkg::ST_TRAILER_CR:  need_val = SIZE_BITS'(1);
         default:                 need_val = SIZE_BITS'(2);
      endcase
   end

   // outputs and post checks
   always_comb begin
      state_nx = st_dec;
      rem_nx   = rem_dec;
      kind     = kind_dec;
      bad      = bad_dec;
      size_val = '0;
      if (!err && !bad && kind == ctd_pkg::KIND_HEADER) begin
         if (huge) begin
            bad = 1'b1;
         end else begin
            size_val = rem_dec;
         end
      end
      if (!err && !bad && kind == ctd_pkg::KIND_DONE) begin
         state_nx = ctd_pkg::ST_START;
         rem_nx   = '0;
      end
      if (!err && !bad && kind != ctd_pkg::KIND_DONE && req.buffer_end && huge) begin
         bad = 1'b1;
      end
      err_nx   = err || bad;
      size_ext = {32'd0, size_val};
      need_ext = {32'd0, need_val};
      if (err_nx) begin
         rsp.byte_kind          = ctd_pkg::KIND_ERROR;
         rsp.payload_byte       = 8'd0;
         rsp.chunk_size         = 32'd0;
         rsp.bytes_still_needed = 32'd0;
      end else begin
         rsp.byte_kind          = kind;
         rsp.payload_byte       = (kind == ctd_pkg::KIND_PAYLOAD) ? ch : 8'd0;
         rsp.chunk_size         = size_ext[31:0];
         rsp.bytes_still_needed = (req.buffer_end && kind != ctd_pkg::KIND_DONE) ?
                                  need_ext[31:0] : 32'd0;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/chunked_transfer_decoder.sv =====
`default_nettype none
// Chunked transfer decoder: takes one body byte per request and returns one
// result per byte (framing, chunk header with its size, payload byte, message
// done or error). It accepts a byte every clock cycle while the result side
// is not stalled; each byte is registered in the request register, and its
// result in the result register. The limit is the per-byte loop through the
// parser state and the size/remaining counter. An error holds until a request
// with restart set. SIZE_BITS sets the width of the internal size counter.
module chunked_transfer_decoder #(
   parameter int SIZE_BITS = ctd_pkg::SIZE_BITS_DEF
) (
   input  wire               clock,
   input  wire               reset,
   ctd_req_if.sink           req_chan,
   ctd_rsp_if.source         rsp_chan
);

   logic                  in_valid_ff;
   ctd_pkg::req_data_type req_ff;
   ctd_pkg::state_type    state_ff;
   ctd_pkg::state_type    state_in;
   logic [SIZE_BITS-1:0]  rem_ff;
   logic [SIZE_BITS-1:0]  rem_in;
   logic                  err_ff;
   logic                  err_in;
   logic                  rsp_valid_ff;
   ctd_pkg::rsp_data_type rsp_ff;
   ctd_pkg::rsp_data_type rsp_in;
   logic                  out_free;
   logic                  advance;

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;

   ctd_step #(
      .SIZE_BITS (SIZE_BITS)
   ) u_step (
      .req       (req_ff),
      .state_cur (state_ff),
      .rem_cur   (rem_ff),
      .err_cur   (err_ff),
      .state_nx  (state_in),
      .rem_nx    (rem_in),
      .err_nx    (err_in),
      .rsp       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ctd_pkg::ST_START;
         rem_ff       <= '0;
         err_ff       <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            state_ff <= state_in;
            rem_ff   <= rem_in;
            err_ff   <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         req_ff <= req_chan.payload;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/ctd_checker.sv =====
`default_nettype none
module ctd_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   rsp_valid,
   input wire                   rsp_ready,
   input ctd_pkg::rsp_data_type rsp_payload
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_payload_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.byte_kind != ctd_pkg::KIND_PAYLOAD |->
         rsp_payload.payload_byte == 8'd0)
      else $error("payload byte set on non-payload result");

   a_size_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.byte_kind != ctd_pkg::KIND_HEADER |->
         rsp_payload.chunk_size == 32'd0)
      else $error("chunk size set on non-header result");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.byte_kind == ctd_pkg::KIND_ERROR ||
                    rsp_payload.byte_kind == ctd_pkg::KIND_DONE) |->
         rsp_payload.bytes_still_needed == 32'd0)
      else $error("remaining count set on error or done result");

endmodule

bind chunked_transfer_decoder ctd_checker u_ctd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
`default_nettype wire

// ===== sim/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ctd_pkg::*;

   localparam int          SIZE_BITS           = SIZE_BITS_DEF;
   localparam logic [63:0] SIZE_MAX            = (64'd1 << SIZE_BITS) - 64'd1;
   localparam int          STALL_MAX           = 12;
   localparam int          BACKPRESSURE_CYCLES = 300;
   localparam int          RANDOM_BYTES        = 1400;
   localparam int          WATCHDOG_LIMIT      = 3000;
   localparam int          DRAIN_CYCLES        = 10;

   logic clock;
   logic reset;

   ctd_req_if req_if ();
   ctd_rsp_if rsp_if ();

   chunked_transfer_decoder u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // decoder state as the testbench expects it
   state_type    dec_state;
   logic [63:0]  dec_count;
   logic         dec_error;

   rsp_data_type pending_decodes[$];
   logic [7:0]   msg_bytes[$];
   int           error_count;
   int unsigned  bytes_sent;
   int           idle_cycles;
   int           rsp_hold;
   bit           req_idle_on;
   bit           rsp_idle_on;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int hex_digit(logic [7:0] ch);
      logic [7:0] folded;
      folded = ch | CASE_BIT;
      if (ch >= "0" && ch <= "9") return int'(ch - "0");
      if (folded >= "a" && folded <= "f") return int'(folded - "a") + 10;
      return -1;
   endfunction

   // lower bound on the bytes the message still needs from the current state
   function automatic logic [63:0] min_remaining();
      case (dec_state)
         ST_START:                    return 64'd3;
         ST_SIZE:                     return 64'd1 + ((dec_count != 0) ? dec_count + 64'd4 : 64'd1);
         ST_EXT, ST_EXT_CR:           return dec_count + 64'd5;
         ST_DATA:                     return dec_count + 64'd4;
         ST_AFTER, ST_AFTER_CR:       return 64'd4;
         ST_LAST_EXT, ST_LAST_EXT_CR: return 64'd2;
         ST_TRAILER, ST_TRAILER_CR:   return 64'd1;
         default:                     return 64'd2;
      endcase
   endfunction

   function automatic rsp_data_type decode_byte(req_data_type rq);
      logic [7:0]   ch;
      kind_type     kind;
      logic [63:0]  announced;
      logic [63:0]  needed;
      logic [7:0]   passed;
      bit           bad;
      int           h;
      rsp_data_type r;
      ch        = rq.data_byte;
      kind      = KIND_FRAME;
      announced = '0;
      needed    = '0;
      passed    = '0;
      bad       = 1'b0;
      if (rq.restart) begin
         dec_state = ST_START;
         dec_count = '0;
         dec_error = 1'b0;
      end
      if (!dec_error) begin
         h = hex_digit(ch);
         case (dec_state)
            ST_START: begin
               if (h < 0) bad = 1'b1;
               else begin
                  dec_count = 64'(h);
                  dec_state = ST_SIZE;
               end
            end
            ST_SIZE: begin
               if (dec_count > SIZE_MAX / 16) bad = 1'b1;
               else if (h >= 0) dec_count = dec_count * 16 + 64'(h);
               else if (ch == CH_CR)
                  dec_state = (dec_count != 0) ? ST_EXT_CR : ST_LAST_EXT_CR;
               else if (ch == CH_LF) begin
                  dec_state = (dec_count != 0) ? ST_DATA : ST_TRAILER;
                  kind      = KIND_HEADER;
               end else if (ch == CH_SEMI || ch == CH_SPACE || ch == CH_TAB)
                  dec_state = (dec_count != 0) ? ST_EXT : ST_LAST_EXT;
               else bad = 1'b1;
            end
            ST_EXT: begin
               if (ch == CH_CR) dec_state = ST_EXT_CR;
               else if (ch == CH_LF) begin
                  dec_state = ST_DATA;
                  kind      = KIND_HEADER;
               end
            end
            ST_EXT_CR: begin
               if (ch != CH_LF) bad = 1'b1;
               else begin
                  dec_state = ST_DATA;
                  kind      = KIND_HEADER;
               end
            end
            ST_DATA: begin
               kind   = KIND_PAYLOAD;
               passed = ch;
               if (dec_count != 0) dec_count = dec_count - 64'd1;
               if (dec_count == 0) dec_state = ST_AFTER;
            end
            ST_AFTER: begin
               if (ch == CH_CR) dec_state = ST_AFTER_CR;
               else if (ch == CH_LF) dec_state = ST_START;
            end
            ST_AFTER_CR: begin
               if (ch != CH_LF) bad = 1'b1;
               else dec_state = ST_START;
            end
            ST_LAST_EXT: begin
               if (ch == CH_CR) dec_state = ST_LAST_EXT_CR;
               else if (ch == CH_LF) begin
                  dec_state = ST_TRAILER;
                  kind      = KIND_HEADER;
               end
            end
            ST_LAST_EXT_CR: begin
               if (ch != CH_LF) bad = 1'b1;
               else begin
                  dec_state = ST_TRAILER;
                  kind      = KIND_HEADER;
               end
            end
            ST_TRAILER: begin
               if (ch == CH_CR) dec_state = ST_TRAILER_CR;
               else if (ch == CH_LF) kind = KIND_DONE;
               else dec_state = ST_THDR;
            end
            ST_TRAILER_CR: begin
               if (ch != CH_LF) bad = 1'b1;
               else kind = KIND_DONE;
            end
            ST_THDR: begin
               if (ch == CH_CR) dec_state = ST_THDR_CR;
               else if (ch == CH_LF) dec_state = ST_TRAILER;
            end
            ST_THDR_CR: begin
               if (ch != CH_LF) bad = 1'b1;
               else dec_state = ST_TRAILER;
            end
            default: bad = 1'b1;
         endcase

         if (!bad && kind == KIND_HEADER) begin
            if (dec_count > SIZE_MAX - 64'd5) bad = 1'b1;
            else announced = dec_count;
         end
         if (!bad && kind == KIND_DONE) begin
            dec_state = ST_START;
            dec_count = '0;
         end
         if (!bad && kind != KIND_DONE && rq.buffer_end) begin
            if (dec_count > SIZE_MAX - 64'd5) bad = 1'b1;
            else needed = min_remaining();
         end
         if (bad) dec_error = 1'b1;
      end
      if (dec_error) begin
         kind      = KIND_ERROR;
         announced = '0;
         needed    = '0;
         passed    = '0;
      end
      r.byte_kind          = kind;
      r.payload_byte       = passed;
      r.chunk_size         = announced[31:0];
      r.bytes_still_needed = needed[31:0];
      return r;
   endfunction

   task automatic send_byte(input logic [7:0] data, input bit at_end, input bit rst);
      int           gap;
      req_data_type rq;
      gap           = req_idle_on ? $urandom_range(0, STALL_MAX) : 0;
      rq.data_byte  = data;
      rq.buffer_end = at_end;
      rq.restart    = rst;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.payload <= rq;
      do @(posedge clock); while (!req_if.ready);
      pending_decodes.push_back(decode_byte(rq));
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input bit rst_first, input bit at_end);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i], at_end, rst_first && i == 0);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] text_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
      return b;
   endfunction

   function automatic logic [7:0] hex_char(int v);
      if (v < 10) return 8'("0" + v);
      return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
   endfunction

   function automatic void add_line_end();
      if ($urandom_range(0, 1)) msg_bytes.push_back(CH_CR);
      msg_bytes.push_back(CH_LF);
   endfunction

   function automatic void add_size(logic [63:0] size);
      int digits;
      digits = 1;
      while (digits < 16 && (size >> (4 * digits)) != 0) digits++;
      digits += $urandom_range(0, 1);  // sometimes a leading zero
      for (int i = digits - 1; i >= 0; i--)
         msg_bytes.push_back(hex_char(int'((size >> (4 * i)) & 64'hF)));
   endfunction

   function automatic void add_extension();
      int unsigned n;
      if ($urandom_range(0, 2) != 0) return;
      case ($urandom_range(0, 2))
         0:       msg_bytes.push_back(CH_SEMI);
         1:       msg_bytes.push_back(CH_SPACE);
         default: msg_bytes.push_back(CH_TAB);
      endcase
      n = $urandom_range(0, 4);
      repeat (n) msg_bytes.push_back(text_byte());
   endfunction

   task automatic test_basic_message();
      req_idle_on = 1'b1;
      send_text("2;x\015\012", 1'b1, 1'b1);
      send_byte(8'h00, 1'b1, 1'b0);
      send_byte(8'hFF, 1'b1, 1'b0);
      // last chunk, one trailer line, then the closing empty line
      send_text("\015\0120\015\012T:\012\015\012", 1'b0, 1'b1);
   endtask

   task automatic test_bad_bytes();
      send_text("g1", 1'b1, 1'b1);
      send_text("1#", 1'b1, 1'b0);
      send_text("1\015x", 1'b1, 1'b0);
   endtask

   task automatic test_size_limits();
      send_text("fffffffa\012", 1'b1, 1'b1);
      send_text("FFFFFFFB\012", 1'b1, 1'b0);
      send_text("100000000", 1'b1, 1'b0);
   endtask

   task automatic test_backpressure();
      req_idle_on = 1'b0;
      rsp_hold    = BACKPRESSURE_CYCLES;
      send_text("10\015\012", 1'b1, 1'b0);
      repeat (16) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_text("\015\0120\012\012", 1'b0, 1'b0);
      wait_drained();
   endtask

   task automatic test_random_messages();
      int unsigned start_count;
      int unsigned pick;
      int unsigned n;
      int unsigned len;
      bit          restart_next;
      start_count  = bytes_sent;
      restart_next = 1'b1;
      while (bytes_sent - start_count < RANDOM_BYTES) begin
         req_idle_on = ($urandom_range(0, 3) != 0);
         pick        = $urandom_range(0, 9);
         msg_bytes.delete();
         if (pick == 1) begin
            // oversized chunk: huge announced size or a size that overflows
            if ($urandom_range(0, 1)) begin
               add_size({32'h0, 4'hF, 28'($urandom)});
               if ($urandom_range(0, 1)) add_line_end();
               n = $urandom_range(0, 4);
               repeat (n) msg_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
               msg_bytes.push_back(hex_char($urandom_range(1, 15)));
               n = $urandom_range(8, 10);
               repeat (n) msg_bytes.push_back(hex_char($urandom_range(0, 15)));
            end
         end else if (pick == 2) begin
            n = $urandom_range(1, 8);
            repeat (n) msg_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            n = $urandom_range(0, 3);
            repeat (n) begin
               len = $urandom_range(1, 20);
               add_size(64'(len));
               add_extension();
               add_line_end();
               repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
               add_line_end();
            end
            add_size(64'd0);
            add_extension();
            add_line_end();
            n = $urandom_range(0, 2);
            repeat (n) begin
               len = $urandom_range(1, 6);
               repeat (len) msg_bytes.push_back(text_byte());
               add_line_end();
            end
            add_line_end();
            if (pick == 0)
               msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
         end
         if ($urandom_range(0, 9) == 0) restart_next = 1'b1;
         foreach (msg_bytes[i])
            send_byte(msg_bytes[i], $urandom_range(0, 7) == 0, restart_next && i == 0);
         restart_next = (pick <= 2);
      end
   endtask

   // result side: random stalls, plus one long hold-off on request
   initial begin
      rsp_data_type got;
      rsp_data_type want;
      int           stall;
      rsp_if.ready = 1'b0;
      rsp_idle_on  = 1'b1;
      do @(posedge clock); while (reset);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, STALL_MAX) : 0;
         if (rsp_hold > 0) begin
            stall    = rsp_hold;
            rsp_hold = 0;
         end
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (!rsp_if.valid);
         got = rsp_if.payload;
         if (pending_decodes.size() == 0) begin
            error_count++;
            $display("%0t: result with no request pending, actual %h", $time, got);
         end else begin
            want = pending_decodes.pop_front();
            if (got.byte_kind !== want.byte_kind) begin
               error_count++;
               $display("%0t: byte_kind expected %0d actual %0d",
                        $time, want.byte_kind, got.byte_kind);
            end
            if (got.payload_byte !== want.payload_byte) begin
               error_count++;
               $display("%0t: payload_byte expected %h actual %h",
                        $time, want.payload_byte, got.payload_byte);
            end
            if (got.chunk_size !== want.chunk_size) begin
               error_count++;
               $display("%0t: chunk_size expected %h actual %h",
                        $time, want.chunk_size, got.chunk_size);
            end
            if (got.bytes_still_needed !== want.bytes_still_needed) begin
               error_count++;
               $display("%0t: bytes_still_needed expected %h actual %h",
                        $time, want.bytes_still_needed, got.bytes_still_needed);
            end
         end
         if ($urandom_range(0, 49) == 0) rsp_idle_on = !rsp_idle_on;
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.payload = '0;
      error_count    = 0;
      bytes_sent     = 0;
      idle_cycles    = 0;
      rsp_hold       = 0;
      req_idle_on    = 1'b1;
      dec_state      = ST_START;
      dec_count      = '0;
      dec_error      = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_basic_message();
      test_bad_bytes();
      test_size_limits();
      test_backpressure();
      test_random_messages();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_decodes.size() != 0) begin
         error_count++;
         $display("%0t: %0d results never arrived", $time, pending_decodes.size());
      end
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
